// ===== sv/npsh_pkg.sv =====
// Shared types, constants and the hash step for the normalized path string hash.
package npsh_pkg;

	localparam int HASH_W = 28;
	localparam int SUM_W = 29;
	localparam int TAG_MAX = 32;
	localparam logic [2:0] SCHEME_LEN = 3'd5;

	// Enclosure tag, zero padded to the longest supported tag
	localparam logic [7:0] TAG_BYTES [TAG_MAX] = '{
		8'h73, 8'h65, 8'h73, 8'h2d, 8'h65, 8'h6e, 8'h63, 8'h6c,
		8'h6f, 8'h73, 8'h75, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Scan phase, one-hot
	typedef enum logic [5:0] {
		PH_SCHEME   = 6'b000001,
		PH_SEARCH   = 6'b000010,
		PH_SKIP_ONE = 6'b000100,
		PH_DIGITS   = 6'b001000,
		PH_SUFFIX   = 6'b010000,
		PH_PLAIN    = 6'b100000
	} phase_t;

	// One result beat
	typedef struct packed {
		logic [SUM_W-1:0] hash_value;
		logic             tag_found;
	} result_t;

	// Byte of the "hc://" scheme at a given position
	function automatic logic [7:0] scheme_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h68;
			3'd1: b = 8'h63;
			3'd2: b = 8'h3a;
			3'd3: b = 8'h2f;
			3'd4: b = 8'h2f;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// One PJW/ELF step; the top nibble always folds back to zero
	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
			input logic [7:0] c);
		logic [31:0] t;
		logic [3:0]  g;
		t = {h, 4'b0000} + {24'd0, c};
		g = t[31:28];
		return t[27:0] ^ {20'd0, g, 4'b0000};
	endfunction

endpackage

// ===== sv/npsh_in_if.sv =====
// Input channel: one string byte per beat with a last-byte marker.
interface npsh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       is_last;

	modport source(output valid, output char_byte, output is_last, input ready);
	modport sink(input valid, input char_byte, input is_last, output ready);
endinterface

// ===== sv/npsh_out_if.sv =====
// Output channel: one hash result per beat.
interface npsh_out_if import npsh_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] hash_value;
	logic             tag_found;

	modport source(output valid, output hash_value, output tag_found, input ready);
	modport sink(input valid, input hash_value, input tag_found, output ready);
endinterface

// ===== sv/normalized_path_string_hash.sv =====
// Streaming PJW/ELF name hash with enclosure-instance normalization: the block takes one
// string byte per cycle on in_ch and, for the byte marked last, delivers one result beat on
// out_ch from the output register, via the skid register while out_ch stalls. Every byte is
// folded into the hash, the scheme check and the tag matcher as it is accepted, so input
// rate is one byte per clock; a two-deep output stage (output register plus skid register)
// keeps bytes flowing while a result waits, and in_ch.ready drops only when both are full.
// normalize_enable (APB byte address 0, bit 0, reset 1) is sampled on the last byte.
module normalized_path_string_hash import npsh_pkg::*; #(
	parameter int TAG_LENGTH = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	npsh_in_if.sink     in_ch,
	npsh_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_NORMALIZE = 1'b0;

	logic    norm_en_q;
	logic    in_fire;
	logic    res_valid;
	logic    out_free;
	logic    out_vld_q;
	logic    skid_vld_q;
	result_t res;
	result_t out_q;
	result_t skid_q;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_NORMALIZE) begin
			norm_en_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_NORMALIZE) begin
			prdata = {31'd0, norm_en_q};
		end
	end

	// Input beat
	assign in_ch.ready = !skid_vld_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign res_valid   = in_fire && in_ch.is_last;

	npsh_scan #(
		.TAG_LENGTH(TAG_LENGTH)
	) u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (in_fire),
		.char_byte        (in_ch.char_byte),
		.is_last          (in_ch.is_last),
		.normalize_enable (norm_en_q),
		.res              (res)
	);

	// Output register with skid stage
	assign out_free = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= res_valid;
			end else begin
				out_vld_q  <= res_valid;
			end
		end else if (res_valid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
				if (res_valid) begin
					skid_q <= res;
				end
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.hash_value = out_q.hash_value;
	assign out_ch.tag_found  = out_q.tag_found;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	a_stalled_result_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_vld_q && !out_ch.ready |=> skid_vld_q)
		else $error("result lost while output stalled");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_ch.ready && !skid_vld_q && !res_valid |=> !out_vld_q)
		else $error("output beat repeated after handoff");

endmodule

// ===== sv/npsh_scan.sv =====
// Per-string scan state: running hash, tag matcher, history line and phase.
module npsh_scan import npsh_pkg::*; #(
	parameter int TAG_LENGTH = 13
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] char_byte,
	input  logic       is_last,
	input  logic       normalize_enable,
	output result_t    res
);

	phase_t              phase_q, phase_d;
	logic [2:0]          scheme_q, scheme_d;
	logic [TAG_LENGTH-1:0] match_q, match_d, hit;
	logic [HASH_W-1:0]   run_q, run_d;
	logic [HASH_W-1:0]   prefix_q, prefix_d;
	logic [HASH_W-1:0]   suffix_q, suffix_d;
	logic [HASH_W-1:0]   hist_q [TAG_LENGTH];
	logic [HASH_W-1:0]   hist_d [TAG_LENGTH];
	logic                scanning;
	logic                full;
	logic                normalized;

	// Shift-and matcher: bit i set when the text ends with the first i+1 tag bytes
	always_comb begin
		for (int i = 0; i < TAG_LENGTH; i++) begin
			if (i == 0) begin
				hit[i] = (char_byte == TAG_BYTES[i]);
			end else begin
				hit[i] = match_q[i-1] && (char_byte == TAG_BYTES[i]);
			end
		end
		full = hit[TAG_LENGTH-1];
	end

	// History line as it stands after this byte shifts in
	always_comb begin
		for (int i = 0; i < TAG_LENGTH; i++) begin
			if (i == 0) begin
				hist_d[i] = run_q;
			end else begin
				hist_d[i] = hist_q[i-1];
			end
		end
	end

	// Next string state for the byte on the input
	always_comb begin
		scanning = (phase_q == PH_SCHEME) || (phase_q == PH_SEARCH);
		phase_d  = phase_q;
		scheme_d = scheme_q;
		match_d  = match_q;
		prefix_d = prefix_q;
		suffix_d = suffix_q;
		run_d    = hash_step(run_q, char_byte);
		if (scanning) begin
			match_d = full ? '0 : hit;
		end
		unique case (phase_q)
			PH_SCHEME: begin
				if (scheme_q < SCHEME_LEN && char_byte == scheme_byte(scheme_q)) begin
					scheme_d = scheme_q + 3'd1;
					if (scheme_q == SCHEME_LEN - 3'd1) begin
						phase_d = PH_SEARCH;
					end
				end else begin
					phase_d = PH_PLAIN;
				end
			end
			PH_SEARCH: begin
				if (full) begin
					prefix_d = hist_d[TAG_LENGTH-1];
					phase_d  = PH_SKIP_ONE;
				end
			end
			PH_SKIP_ONE: begin
				phase_d = PH_DIGITS;
			end
			PH_DIGITS: begin
				if (char_byte < CHAR_ZERO || char_byte > CHAR_NINE) begin
					suffix_d = hash_step(suffix_q, char_byte);
					phase_d  = PH_SUFFIX;
				end
			end
			PH_SUFFIX: begin
				suffix_d = hash_step(suffix_q, char_byte);
			end
			PH_PLAIN: begin
				phase_d = PH_PLAIN;
			end
			default: begin
				phase_d = PH_PLAIN;
			end
		endcase
	end

	// Pick the normalized sum or the whole-string hash
	always_comb begin
		normalized = normalize_enable &&
			((phase_d == PH_SKIP_ONE) || (phase_d == PH_DIGITS) || (phase_d == PH_SUFFIX));
		res.tag_found = normalized;
		if (normalized) begin
			res.hash_value = {1'b0, prefix_d} + {1'b0, suffix_d};
		end else begin
			res.hash_value = {1'b0, run_d};
		end
	end

	// Advance on each beat; return to the start state after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SCHEME;
			scheme_q <= '0;
			match_q  <= '0;
			run_q    <= '0;
			prefix_q <= '0;
			suffix_q <= '0;
		end else if (fire) begin
			if (is_last) begin
				phase_q  <= PH_SCHEME;
				scheme_q <= '0;
				match_q  <= '0;
				run_q    <= '0;
				prefix_q <= '0;
				suffix_q <= '0;
			end else begin
				phase_q  <= phase_d;
				scheme_q <= scheme_d;
				match_q  <= match_d;
				run_q    <= run_d;
				prefix_q <= prefix_d;
				suffix_q <= suffix_d;
			end
		end
	end

	// Shift the history line while the tag can still be found
	always_ff @(posedge clk) begin
		if (fire && scanning) begin
			for (int i = 0; i < TAG_LENGTH; i++) begin
				hist_q[i] <= hist_d[i];
			end
		end
	end

	a_match_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!match_q[TAG_LENGTH-1])
		else $error("stored tag match holds a full match");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_last |=> phase_q == PH_SCHEME && scheme_q == 3'd0 && run_q == '0)
		else $error("scan state not restarted after last byte");

	a_search_after_scheme: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> scheme_q == SCHEME_LEN)
		else $error("tag search entered without full scheme");

endmodule

// ===== dv/hash_result_check.sv =====
// Checker for the name hash block: predicts each string's hash and compares result beats.
`timescale 1ns / 1ps

module hash_result_check import npsh_pkg::*; #(
	parameter logic [2:0] CFG_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	npsh_in_if          in_mon,
	npsh_out_if         out_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          pending
);

	localparam int TAG_LEN = 13;
	localparam int SCHEME_N = 5;
	localparam logic [7:0] SCHEME_STR [SCHEME_N] = '{8'h68, 8'h63, 8'h3a, 8'h2f, 8'h2f};

	// Shadow of the block's per-string state and its one register
	logic              norm_en;
	logic [HASH_W-1:0] run_h;
	logic [HASH_W-1:0] prior_h [TAG_LEN];
	logic [HASH_W-1:0] head_h;
	logic [HASH_W-1:0] tail_h;
	int                tag_hits;
	int                scheme_hits;
	phase_t            scan;
	result_t           expected_hashes [$];
	result_t           want;

	// PJW/ELF step, computed over 32 bits and folded back under 28
	function automatic logic [HASH_W-1:0] elf_fold(input logic [HASH_W-1:0] h,
			input logic [7:0] c);
		logic [31:0] acc;
		logic [31:0] hi;
		acc = {h, 4'h0} + {24'h0, c};
		hi = acc & 32'hf000_0000;
		if (hi != 0) begin
			acc = acc ^ (hi >> 24);
			acc = acc ^ hi;
		end
		return acc[HASH_W-1:0];
	endfunction

	// Longest tag head that ends the text matched so far plus this byte
	function automatic int tag_advance(input int p, input logic [7:0] c);
		int  k;
		int  j;
		bit  ok;
		if (p >= TAG_LEN)
			p = 0;
		for (k = p + 1; k >= 1; k--) begin
			ok = (TAG_BYTES[k-1] == c);
			for (j = 0; ok && j + 1 < k; j++) begin
				if (TAG_BYTES[j] != TAG_BYTES[p+1-k+j])
					ok = 0;
			end
			if (ok)
				return k;
		end
		return 0;
	endfunction

	task automatic clear_name();
		run_h = '0;
		foreach (prior_h[i])
			prior_h[i] = '0;
		head_h = '0;
		tail_h = '0;
		tag_hits = 0;
		scheme_hits = 0;
		scan = PH_SCHEME;
	endtask

	// Fold one accepted byte into the shadow state; queue a result on the last byte
	task automatic fold_name_byte(input logic [7:0] c, input logic last);
		result_t res;
		if (scan == PH_SCHEME || scan == PH_SEARCH) begin
			for (int i = TAG_LEN - 1; i > 0; i--)
				prior_h[i] = prior_h[i-1];
			prior_h[0] = run_h;
			tag_hits = tag_advance(tag_hits, c);
		end
		case (scan)
			PH_SCHEME: begin
				if (scheme_hits < SCHEME_N && c == SCHEME_STR[scheme_hits]) begin
					scheme_hits++;
					if (scheme_hits == SCHEME_N)
						scan = PH_SEARCH;
				end else begin
					scan = PH_PLAIN;
				end
			end
			PH_SEARCH: begin
				if (tag_hits >= TAG_LEN) begin
					head_h = prior_h[TAG_LEN-1];
					scan = PH_SKIP_ONE;
				end
			end
			PH_SKIP_ONE: begin
				scan = PH_DIGITS;
			end
			PH_DIGITS: begin
				if (c < CHAR_ZERO || c > CHAR_NINE) begin
					tail_h = elf_fold(tail_h, c);
					scan = PH_SUFFIX;
				end
			end
			PH_SUFFIX: begin
				tail_h = elf_fold(tail_h, c);
			end
			default: ;
		endcase
		if (tag_hits >= TAG_LEN)
			tag_hits = 0;
		run_h = elf_fold(run_h, c);
		if (last) begin
			if (norm_en && (scan == PH_SKIP_ONE || scan == PH_DIGITS || scan == PH_SUFFIX)) begin
				res.hash_value = {1'b0, head_h} + {1'b0, tail_h};
				res.tag_found = 1'b1;
			end else begin
				res.hash_value = {1'b0, run_h};
				res.tag_found = 1'b0;
			end
			expected_hashes.push_back(res);
			clear_name();
		end
	endtask

	// Watch register writes, result beats and byte beats at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_en = 1'b1;
			clear_name();
			expected_hashes.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CFG_ADDR)
				norm_en = pwdata[0];
			if (out_mon.valid && out_mon.ready) begin
				if (expected_hashes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: hash %h tag %0d",
							out_mon.hash_value, out_mon.tag_found);
				end else begin
					want = expected_hashes.pop_front();
					if (want.hash_value !== out_mon.hash_value ||
							want.tag_found !== out_mon.tag_found) begin
						mismatches++;
						if (mismatches <= 10)
							$display("hash mismatch: expected hash %h tag %0d, got hash %h tag %0d",
								want.hash_value, want.tag_found,
								out_mon.hash_value, out_mon.tag_found);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				fold_name_byte(in_mon.char_byte, in_mon.is_last);
			pending = expected_hashes.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the name hash testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module testbench import npsh_pkg::*;;

	localparam logic [2:0] NORM_EN_ADDR = 3'd0;
	localparam int TAG_LEN = 13;
	localparam int PHASE_BYTES = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT = 3000;
	localparam logic [7:0] SCHEME_STR [5] = '{8'h68, 8'h63, 8'h3a, 8'h2f, 8'h2f};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          pending;
	int          stall_count;
	int          bytes_sent;
	bit          calm;
	bit          hold_req;
	logic [7:0]  name_q [$];

	npsh_in_if  in_ch ();
	npsh_out_if out_ch ();

	normalized_path_string_hash u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hash_result_check #(.CFG_ADDR(NORM_EN_ADDR)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// End the run when nothing has been accepted for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	// Result receiver: random stalls, a calm stretch and one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ch.ready = arst_n && (calm || $urandom_range(99) >= 32);
		end
	end

	task automatic put_byte(input logic [7:0] c, input logic last);
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.char_byte = c;
		in_ch.is_last = last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_ch.valid = 1'b0;
		in_ch.char_byte = 8'($urandom);
		in_ch.is_last = 1'($urandom);
	endtask

	// Send name_q from a start index, with random gaps between beats
	task automatic send_name(input int from, input bit close);
		for (int i = from; i < name_q.size(); i++) begin
			while (!calm && $urandom_range(99) < 32)
				drop_valid();
			put_byte(name_q[i], close && i == name_q.size() - 1);
		end
	endtask

	task automatic load_text(input string s);
		name_q.delete();
		for (int i = 0; i < s.len(); i++)
			name_q.push_back(s[i]);
	endtask

	// Hold the sender until every result is out, then let the block settle
	task automatic drain();
		drop_valid();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_norm_en(input logic v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = NORM_EN_ADDR;
		pwdata = $urandom;
		pwdata[0] = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Build one name: mostly well-formed "hc://...tag..." paths, then broken schemes and noise
	task automatic build_name();
		int kind;
		int cut;
		int tag_end;
		int i;
		kind = $urandom_range(99);
		name_q.delete();
		if (kind < 55) begin
			for (i = 0; i < 5; i++)
				name_q.push_back(SCHEME_STR[i]);
			repeat ($urandom_range(5)) begin
				case ($urandom_range(2))
					0: name_q.push_back(8'($urandom));
					1: name_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
					default: begin
						cut = $urandom_range(1, 6);
						for (i = 0; i < cut; i++)
							name_q.push_back(TAG_BYTES[i]);
					end
				endcase
			end
			for (i = 0; i < TAG_LEN; i++)
				name_q.push_back(TAG_BYTES[i]);
			// near miss: damage one tag byte
			if ($urandom_range(9) == 0)
				name_q[name_q.size() - 1 - $urandom_range(TAG_LEN - 1)] = 8'($urandom);
			tag_end = name_q.size();
			name_q.push_back(8'($urandom));
			repeat ($urandom_range(4))
				name_q.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
			repeat ($urandom_range(6)) begin
				if ($urandom_range(1) == 0)
					name_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
				else
					name_q.push_back(8'($urandom));
			end
			// a second tag in the suffix is hashed as plain text
			if ($urandom_range(9) == 0) begin
				for (i = 0; i < TAG_LEN; i++)
					name_q.push_back(TAG_BYTES[i]);
			end
			// end on the tag, on the byte after it, or anywhere
			case ($urandom_range(9))
				0: cut = tag_end;
				1: cut = tag_end + 1;
				2: cut = $urandom_range(1, name_q.size());
				default: cut = name_q.size();
			endcase
			while (name_q.size() > cut)
				void'(name_q.pop_back());
		end else if (kind < 70) begin
			for (i = 0; i < 5; i++)
				name_q.push_back(SCHEME_STR[i]);
			name_q[$urandom_range(4)] = 8'($urandom);
			cut = $urandom_range(1, 5);
			while (name_q.size() > cut)
				void'(name_q.pop_back());
			repeat ($urandom_range(6))
				name_q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8))
				name_q.push_back(8'($urandom));
		end
	endtask

	// Stimulus and verdict
	initial begin
		int split;
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.char_byte = '0;
		in_ch.is_last = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes, zero byte, short string, tag at end
		name_q = '{8'h00};
		send_name(0, 1'b1);
		name_q = '{8'hff};
		send_name(0, 1'b1);
		load_text("hc");
		send_name(0, 1'b1);
		load_text("hc://ses-enclosure");
		send_name(0, 1'b1);

		// random phases, alternating normalization; odd phases change it mid-string
		for (int p = 0; p < 4; p++) begin
			split = 0;
			if (p % 2 == 1) begin
				build_name();
				split = name_q.size() / 2;
				send_name(0, 1'b0);
				while (name_q.size() > split)
					void'(name_q.pop_back());
			end
			drain();
			write_norm_en(p % 2 == 1);
			if (p % 2 == 1) begin
				build_name();
				send_name(0, 1'b1);
			end
			if (p == 1)
				hold_req = 1'b1;
			calm = (p == 2);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				build_name();
				send_name(0, 1'b1);
			end
			calm = 1'b0;
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/npsh_pkg.sv
sv/npsh_in_if.sv
sv/npsh_out_if.sv
sv/npsh_scan.sv
sv/normalized_path_string_hash.sv
dv/hash_result_check.sv
dv/testbench.sv
